FILE: rtl/fdfa_pkg.sv
// fdfa_pkg: shared types and codes for the fifo dispatcher
// command codes, status codes, controller states and the serving-slot record
// no dependencies
`default_nettype none

package fdfa_pkg;

  localparam int USER_W     = 16;
  localparam int AGENT_W    = 5;
  localparam int AGENT_IN_W = 8;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 4;
  localparam int CFG_W      = 5;

  // agents_in_use after reset
  localparam logic [CFG_W-1:0] CFG_AGENTS_RST = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_JOIN      = 2'd0,
    CMD_SERVE     = 2'd1,
    CMD_REL_AGENT = 2'd2,
    CMD_REL_USER  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_JOINED     = 4'd0,
    STAT_DUP        = 4'd1,
    STAT_EMPTY      = 4'd2,
    STAT_NO_AGENT   = 4'd3,
    STAT_SERVED     = 4'd4,
    STAT_FREED      = 4'd5,
    STAT_ALREADY    = 4'd6,
    STAT_AGENT_UNK  = 4'd7,
    STAT_RELEASED   = 4'd8,
    STAT_USER_UNK   = 4'd9,
    STAT_QUEUE_FULL = 4'd10,
    STAT_TABLE_FULL = 4'd11
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TSCAN,
    S_QSCAN,
    S_FINISH
  } state_t;

  // one serving-table entry
  typedef struct packed {
    logic              vld;
    logic [USER_W-1:0]  user;
    logic [AGENT_W-1:0] agent;
  } slot_t;

  // shift enables for the two cell chains
  typedef struct packed {
    logic q_shift;
    logic t_shift;
  } chain_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/fdfa_qcell.sv
// fdfa_qcell: one cell of the waiting-queue ring
// holds one user id, takes its neighbor's value on shift; uses fdfa_pkg
`default_nettype none

module fdfa_qcell (
  input  wire logic                        clk,
  input  wire logic                        shift,
  input  wire logic [fdfa_pkg::USER_W-1:0] d_in,
  output logic      [fdfa_pkg::USER_W-1:0] q_out
);

  logic [fdfa_pkg::USER_W-1:0] user_r;

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (shift) begin
      user_r <= d_in;
    end
  end

  assign q_out = user_r;

endmodule

`default_nettype wire

FILE: rtl/fdfa_scell.sv
// fdfa_scell: one cell of the serving-table ring
// holds a valid bit, user id and agent, takes its neighbor's entry on shift; uses fdfa_pkg
`default_nettype none

module fdfa_scell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            shift,
  input  wire fdfa_pkg::slot_t d_in,
  output fdfa_pkg::slot_t      q_out
);

  logic                           vld_r;
  logic [fdfa_pkg::USER_W-1:0]  user_r;
  logic [fdfa_pkg::AGENT_W-1:0] agent_r;

  // valid bit cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (shift) begin
      vld_r <= d_in.vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (shift) begin
      user_r  <= d_in.user;
      agent_r <= d_in.agent;
    end
  end

  assign q_out = '{vld: vld_r, user: user_r, agent: agent_r};

endmodule

`default_nettype wire

FILE: rtl/fdfa_ctrl.sv
// fdfa_ctrl: command sequencer of the fifo dispatcher
// looks at the head cell of each ring while the rings rotate, keeps counts,
// agent busy flags, config and the result register; uses fdfa_pkg
`default_nettype none

module fdfa_ctrl #(
  parameter int QUEUE_DEPTH = 64,
  parameter int MAX_AGENTS  = 16,
  parameter int SERVE_SLOTS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [fdfa_pkg::CMD_W-1:0]      in_command,
  input  wire logic [fdfa_pkg::USER_W-1:0]     in_user_id,
  input  wire logic [fdfa_pkg::AGENT_IN_W-1:0] in_agent_id,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [fdfa_pkg::STATUS_W-1:0]   out_status,
  output logic      [fdfa_pkg::AGENT_W-1:0]    out_agent_out,
  output logic      [fdfa_pkg::USER_W-1:0]     out_user_out,
  input  wire logic                            cfg_wr_en,
  input  wire logic [fdfa_pkg::CFG_W-1:0]      cfg_wr_data,
  input  wire logic [fdfa_pkg::USER_W-1:0]     q_head,
  input  wire fdfa_pkg::slot_t                 t_head,
  output fdfa_pkg::chain_ctl_t                 chain_ctl,
  output logic      [fdfa_pkg::USER_W-1:0]     q_wdata,
  output fdfa_pkg::slot_t                      t_wdata
);

  localparam int QCW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SCW    = $clog2(SERVE_SLOTS + 1);
  localparam int MAXD   = (QUEUE_DEPTH > SERVE_SLOTS) ? QUEUE_DEPTH : SERVE_SLOTS;
  localparam int CNT_W  = $clog2(MAXD);
  localparam logic [CNT_W-1:0] Q_LAST = CNT_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] S_LAST = CNT_W'(SERVE_SLOTS - 1);
  localparam logic [QCW-1:0]   Q_FULL = QCW'(QUEUE_DEPTH);
  localparam logic [SCW-1:0]   S_FULL = SCW'(SERVE_SLOTS);

  localparam int UW = fdfa_pkg::USER_W;
  localparam int AW = fdfa_pkg::AGENT_W;

  fdfa_pkg::state_t  state_r, state_nxt;
  fdfa_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [UW-1:0]     user_r, user_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              hit_r, hit_nxt;
  fdfa_pkg::status_t res_status_r, res_status_nxt;
  logic [AW-1:0]     res_agent_r, res_agent_nxt;
  logic [UW-1:0]     res_user_r, res_user_nxt;
  logic [QCW-1:0]    wcount_r, wcount_nxt;
  logic [SCW-1:0]    scount_r, scount_nxt;
  logic [MAX_AGENTS-1:0] busy_r, busy_nxt;
  logic [fdfa_pkg::CFG_W-1:0] cfg_agents_r, cfg_agents_nxt;
  logic              out_valid_r, out_valid_nxt;
  fdfa_pkg::status_t out_status_r, out_status_nxt;
  logic [AW-1:0]     out_agent_r, out_agent_nxt;
  logic [UW-1:0]     out_user_r, out_user_nxt;

  fdfa_pkg::cmd_t    in_cmd;
  logic              accept;
  logic              out_free;
  logic [AW-1:0]     eff_agents;
  logic [MAX_AGENTS-1:0] avail, low_free, rel_mask, slot_mask;
  logic [AW-1:0]     free_agent;
  logic              rel_ok;
  logic              serve_ok;
  logic              t_match;
  logic              q_match;
  logic              q_at_tail;
  logic              dup;

  assign in_cmd   = fdfa_pkg::cmd_t'(in_command);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // agent count clamped to the built number of agents
  assign eff_agents = (8'(cfg_agents_r) > 8'(MAX_AGENTS)) ? AW'(MAX_AGENTS) : cfg_agents_r;

  // free agents and agent masks
  always_comb begin
    for (int i = 0; i < MAX_AGENTS; i++) begin
      avail[i]     = !busy_r[i] && (8'(i) < 8'(eff_agents));
      rel_mask[i]  = (8'(i + 1) == in_agent_id);
      slot_mask[i] = (8'(i + 1) == 8'(t_head.agent));
    end
  end

  // lowest free agent, one-hot, then its number
  assign low_free = avail & (~avail + MAX_AGENTS'(1));
  always_comb begin
    free_agent = '0;
    for (int i = 0; i < MAX_AGENTS; i++) begin
      free_agent = free_agent | ({AW{low_free[i]}} & AW'(i + 1));
    end
  end

  assign rel_ok    = (in_agent_id != '0) && (in_agent_id <= 8'(eff_agents));
  assign serve_ok  = (wcount_r != '0) && (free_agent != '0) && (scount_r != S_FULL);
  assign t_match   = t_head.vld && (t_head.user == user_r);
  assign q_match   = (QCW'(cnt_r) < wcount_r) && (q_head == user_r);
  assign q_at_tail = (QCW'(cnt_r) == wcount_r);
  assign dup       = hit_r || q_match;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fdfa_pkg::S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            fdfa_pkg::CMD_JOIN:      state_nxt = fdfa_pkg::S_TSCAN;
            fdfa_pkg::CMD_SERVE:     state_nxt = serve_ok ? fdfa_pkg::S_TSCAN
                                                          : fdfa_pkg::S_FINISH;
            fdfa_pkg::CMD_REL_AGENT: state_nxt = fdfa_pkg::S_FINISH;
            fdfa_pkg::CMD_REL_USER:  state_nxt = fdfa_pkg::S_TSCAN;
            default:                 state_nxt = fdfa_pkg::S_IDLE;
          endcase
        end
      end
      fdfa_pkg::S_TSCAN: begin
        if (cnt_r == S_LAST) begin
          state_nxt = (cmd_r == fdfa_pkg::CMD_JOIN) ? fdfa_pkg::S_QSCAN : fdfa_pkg::S_FINISH;
        end
      end
      fdfa_pkg::S_QSCAN: begin
        if (cnt_r == Q_LAST) begin
          state_nxt = fdfa_pkg::S_FINISH;
        end
      end
      fdfa_pkg::S_FINISH: begin
        if (out_free) begin
          state_nxt = fdfa_pkg::S_IDLE;
        end
      end
      default: state_nxt = fdfa_pkg::S_IDLE;
    endcase
  end

  // ring control and write-back of the head cells
  always_comb begin
    in_ready          = (state_r == fdfa_pkg::S_IDLE);
    chain_ctl.q_shift = (state_r == fdfa_pkg::S_QSCAN) ||
                        (accept && (in_cmd == fdfa_pkg::CMD_SERVE) && serve_ok);
    chain_ctl.t_shift = (state_r == fdfa_pkg::S_TSCAN);
    // new user goes in at the tail position once all entries were seen
    q_wdata = q_head;
    if ((state_r == fdfa_pkg::S_QSCAN) && q_at_tail && !hit_r) begin
      q_wdata = user_r;
    end
    t_wdata = t_head;
    case (cmd_r)
      fdfa_pkg::CMD_SERVE: begin
        if (!t_head.vld && !hit_r) begin
          t_wdata = '{vld: 1'b1, user: user_r, agent: res_agent_r};
        end
      end
      fdfa_pkg::CMD_REL_USER: begin
        if (t_match && !hit_r) begin
          t_wdata.vld = 1'b0;
        end
      end
      default: t_wdata = t_head;
    endcase
  end

  // datapath and bookkeeping
  always_comb begin
    cmd_nxt        = cmd_r;
    user_nxt       = user_r;
    cnt_nxt        = cnt_r;
    hit_nxt        = hit_r;
    res_status_nxt = res_status_r;
    res_agent_nxt  = res_agent_r;
    res_user_nxt   = res_user_r;
    wcount_nxt     = wcount_r;
    scount_nxt     = scount_r;
    busy_nxt       = busy_r;
    cfg_agents_nxt = cfg_wr_en ? cfg_wr_data : cfg_agents_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_agent_nxt  = out_agent_r;
    out_user_nxt   = out_user_r;

    case (state_r)
      fdfa_pkg::S_IDLE: begin
        if (accept) begin
          cmd_nxt       = in_cmd;
          user_nxt      = in_user_id;
          hit_nxt       = 1'b0;
          cnt_nxt       = '0;
          res_agent_nxt = '0;
          res_user_nxt  = '0;
          case (in_cmd)
            fdfa_pkg::CMD_SERVE: begin
              if (wcount_r == '0) begin
                res_status_nxt = fdfa_pkg::STAT_EMPTY;
              end else if (free_agent == '0) begin
                res_status_nxt = fdfa_pkg::STAT_NO_AGENT;
              end else if (scount_r == S_FULL) begin
                res_status_nxt = fdfa_pkg::STAT_TABLE_FULL;
              end else begin
                // pop the head and claim the agent now, slot is filled in the scan
                res_status_nxt = fdfa_pkg::STAT_SERVED;
                res_agent_nxt  = free_agent;
                res_user_nxt   = q_head;
                user_nxt       = q_head;
                busy_nxt       = busy_r | low_free;
                wcount_nxt     = wcount_r - QCW'(1);
                scount_nxt     = scount_r + SCW'(1);
              end
            end
            fdfa_pkg::CMD_REL_AGENT: begin
              if (!rel_ok) begin
                res_status_nxt = fdfa_pkg::STAT_AGENT_UNK;
              end else begin
                res_agent_nxt = in_agent_id[AW-1:0];
                if ((busy_r & rel_mask) != '0) begin
                  res_status_nxt = fdfa_pkg::STAT_FREED;
                  busy_nxt       = busy_r & ~rel_mask;
                end else begin
                  res_status_nxt = fdfa_pkg::STAT_ALREADY;
                end
              end
            end
            fdfa_pkg::CMD_REL_USER: begin
              res_status_nxt = fdfa_pkg::STAT_USER_UNK;
            end
            default: begin
              res_status_nxt = fdfa_pkg::STAT_JOINED;
            end
          endcase
        end
      end
      fdfa_pkg::S_TSCAN: begin
        cnt_nxt = (cnt_r == S_LAST) ? '0 : cnt_r + CNT_W'(1);
        case (cmd_r)
          fdfa_pkg::CMD_JOIN: begin
            if (t_match) begin
              hit_nxt = 1'b1;
            end
          end
          fdfa_pkg::CMD_SERVE: begin
            if (!t_head.vld) begin
              hit_nxt = 1'b1;
            end
          end
          fdfa_pkg::CMD_REL_USER: begin
            if (t_match && !hit_r) begin
              hit_nxt        = 1'b1;
              res_status_nxt = fdfa_pkg::STAT_RELEASED;
              res_agent_nxt  = t_head.agent;
              res_user_nxt   = user_r;
              busy_nxt       = busy_r & ~slot_mask;
              scount_nxt     = scount_r - SCW'(1);
            end
          end
          default: hit_nxt = hit_r;
        endcase
      end
      fdfa_pkg::S_QSCAN: begin
        cnt_nxt = (cnt_r == Q_LAST) ? '0 : cnt_r + CNT_W'(1);
        if (q_match) begin
          hit_nxt = 1'b1;
        end
        // decide the join once the whole queue went by
        if (cnt_r == Q_LAST) begin
          res_agent_nxt = '0;
          res_user_nxt  = user_r;
          if (dup) begin
            res_status_nxt = fdfa_pkg::STAT_DUP;
          end else if (wcount_r == Q_FULL) begin
            res_status_nxt = fdfa_pkg::STAT_QUEUE_FULL;
          end else begin
            res_status_nxt = fdfa_pkg::STAT_JOINED;
            wcount_nxt     = wcount_r + QCW'(1);
          end
        end
      end
      fdfa_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_agent_nxt  = res_agent_r;
          out_user_nxt   = res_user_r;
        end
      end
      default: cnt_nxt = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fdfa_pkg::S_IDLE;
      cnt_r        <= '0;
      hit_r        <= 1'b0;
      wcount_r     <= '0;
      scount_r     <= '0;
      busy_r       <= '0;
      cfg_agents_r <= fdfa_pkg::CFG_AGENTS_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      hit_r        <= hit_nxt;
      wcount_r     <= wcount_nxt;
      scount_r     <= scount_nxt;
      busy_r       <= busy_nxt;
      cfg_agents_r <= cfg_agents_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    user_r       <= user_nxt;
    res_status_r <= res_status_nxt;
    res_agent_r  <= res_agent_nxt;
    res_user_r   <= res_user_nxt;
    out_status_r <= out_status_nxt;
    out_agent_r  <= out_agent_nxt;
    out_user_r   <= out_user_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_agent_out = out_agent_r;
  assign out_user_out  = out_user_r;

endmodule

`default_nettype wire

FILE: rtl/fifo_dispatch_to_free_agents.sv
// fifo_dispatch_to_free_agents: top level of the fifo dispatcher
// two rings of cells (waiting queue, serving table) around one sequencer;
// uses fdfa_pkg, fdfa_qcell, fdfa_scell, fdfa_ctrl
//
// Usage
//   in_*  : one request per accept (in_valid & in_ready): command, user id, agent id.
//   out_* : one result per request: status, agent, user; held until out_ready.
//   cfg_* : cfg_wr_en writes agents_in_use at once; write only while idle.
// Steps per request
//   release agent : no ring turn; the result is registered from the finish state
//   serve, release user : a whole turn of the serving-table ring, then finish
//   serve that fails its checks : as release agent
//   join : a whole turn of the serving-table ring, then of the waiting queue, then finish
//   The steps are set by the rings: each lookup rotates a whole ring past the
//   sequencer, one cell a cycle, and a join walks both rings.
// One request is in work at a time; in_ready is high when the sequencer is idle,
// also while an earlier result still waits in the output register.
// Stall: a finished result waits in the sequencer until the output register frees.
// Reset (rst_n low, synchronous): queue empty, all agents free, table slots invalid,
// agents_in_use back to 16, no result pending.
`default_nettype none

module fifo_dispatch_to_free_agents #(
  parameter int QUEUE_DEPTH = 64,
  parameter int MAX_AGENTS  = 16,
  parameter int SERVE_SLOTS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [fdfa_pkg::CMD_W-1:0]      in_command,
  input  wire logic [fdfa_pkg::USER_W-1:0]     in_user_id,
  input  wire logic [fdfa_pkg::AGENT_IN_W-1:0] in_agent_id,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [fdfa_pkg::STATUS_W-1:0]   out_status,
  output logic      [fdfa_pkg::AGENT_W-1:0]    out_agent_out,
  output logic      [fdfa_pkg::USER_W-1:0]     out_user_out,
  input  wire logic                            cfg_wr_en,
  input  wire logic [fdfa_pkg::CFG_W-1:0]      cfg_wr_data
);

  logic [fdfa_pkg::USER_W-1:0] q_data [QUEUE_DEPTH];
  fdfa_pkg::slot_t             t_data [SERVE_SLOTS];
  logic [fdfa_pkg::USER_W-1:0] q_wdata;
  fdfa_pkg::slot_t             t_wdata;
  fdfa_pkg::chain_ctl_t        chain_ctl;

  // sequencer
  fdfa_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_AGENTS  (MAX_AGENTS),
    .SERVE_SLOTS (SERVE_SLOTS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_user_id    (in_user_id),
    .in_agent_id   (in_agent_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_agent_out (out_agent_out),
    .out_user_out  (out_user_out),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .q_head        (q_data[0]),
    .t_head        (t_data[0]),
    .chain_ctl     (chain_ctl),
    .q_wdata       (q_wdata),
    .t_wdata       (t_wdata)
  );

  // waiting queue ring, head at cell 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_qcell
    if (i == QUEUE_DEPTH - 1) begin : g_last
      fdfa_qcell u_cell (
        .clk   (clk),
        .shift (chain_ctl.q_shift),
        .d_in  (q_wdata),
        .q_out (q_data[i])
      );
    end else begin : g_mid
      fdfa_qcell u_cell (
        .clk   (clk),
        .shift (chain_ctl.q_shift),
        .d_in  (q_data[i+1]),
        .q_out (q_data[i])
      );
    end
  end

  // serving table ring, cell 0 seen by the sequencer
  for (genvar i = 0; i < SERVE_SLOTS; i++) begin : g_scell
    if (i == SERVE_SLOTS - 1) begin : g_last
      fdfa_scell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (chain_ctl.t_shift),
        .d_in  (t_wdata),
        .q_out (t_data[i])
      );
    end else begin : g_mid
      fdfa_scell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (chain_ctl.t_shift),
        .d_in  (t_data[i+1]),
        .q_out (t_data[i])
      );
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fdfa_checker.sv
// fdfa_checker: port-level checks for the fifo dispatcher, bound to the top level
// sees the top-level ports only; uses fdfa_pkg
`default_nettype none

module fdfa_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic [fdfa_pkg::CMD_W-1:0]      in_command,
  input wire logic [fdfa_pkg::USER_W-1:0]     in_user_id,
  input wire logic [fdfa_pkg::AGENT_IN_W-1:0] in_agent_id,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [fdfa_pkg::STATUS_W-1:0]   out_status,
  input wire logic [fdfa_pkg::AGENT_W-1:0]    out_agent_out,
  input wire logic [fdfa_pkg::USER_W-1:0]     out_user_out,
  input wire logic                            cfg_wr_en,
  input wire logic [fdfa_pkg::CFG_W-1:0]      cfg_wr_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_agent_out) && $stable(out_user_out))
    else $error("stalled result changed");

  // one request in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  // a served request names an agent
  a_served_agent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == fdfa_pkg::STAT_SERVED) |-> out_agent_out != '0)
    else $error("served without an agent");

  // failures that touch no agent report agent 0 and user 0
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == fdfa_pkg::STAT_EMPTY ||
                  out_status == fdfa_pkg::STAT_NO_AGENT ||
                  out_status == fdfa_pkg::STAT_TABLE_FULL ||
                  out_status == fdfa_pkg::STAT_AGENT_UNK ||
                  out_status == fdfa_pkg::STAT_USER_UNK)
    |-> (out_agent_out == '0) && (out_user_out == '0))
    else $error("failure status with agent or user set");

  // a reset clears any pending result
  a_no_early_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind fifo_dispatch_to_free_agents fdfa_checker u_fdfa_checker (.*);

`default_nettype wire
